// ===== src/mrsa_pkg.sv =====
// ---------------------------------------------------------------------------
// mrsa_pkg - shared definitions for the memory region statistics accumulator
// Field widths, request and region codes, and the controller/datapath bundles.
// ---------------------------------------------------------------------------
package mrsa_pkg;

   localparam int TOP_SLOTS   = 8;
   localparam int NUM_TOTALS  = 5;
   localparam int NUM_KEPT    = TOP_SLOTS - 1;
   localparam int NUM_STATS   = 2 * NUM_TOTALS + NUM_KEPT;
   localparam int STEP_W      = $clog2(NUM_STATS);
   localparam int TOT_IDX_W   = $clog2(NUM_TOTALS);
   localparam int KEPT_IDX_W  = (NUM_KEPT > 1) ? $clog2(NUM_KEPT) : 1;

   localparam int ADDR_W      = 48;
   localparam int MASK_W      = 32;
   localparam int SUM_W       = 64;
   localparam int COUNT_W     = 32;
   localparam int INDEX_W     = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // totals slots
   localparam int TOT_MAPPED  = 0;
   localparam int TOT_FREE    = 1;
   localparam int TOT_WASTE   = 2;
   localparam int TOT_EXEC    = 3;
   localparam int TOT_RESV    = 4;

   typedef enum logic [1:0] {
      REQ_REGION = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   localparam logic [1:0] REGION_COMMITTED = 2'd0;
   localparam logic [1:0] REGION_RESERVED  = 2'd1;
   localparam logic [1:0] REGION_FREE      = 2'd2;

   // register index within the CSR space (paddr bit 2)
   localparam logic CSR_GRANULE_MASK = 1'b0;
   localparam logic CSR_EXEC_MASK    = 1'b1;

   typedef struct packed {
      logic              load;
      logic              clear;
      logic              calc_up;
      logic              calc_gap;
      logic              update;
      logic              shift;
      logic              shift_last;
      logic              emit;
      logic              emit_last;
      logic [STEP_W-1:0] step;
   } mrsa_cmd_type;

   typedef struct packed {
      logic free_hit;
      logic out_room;
   } mrsa_status_type;

endpackage

// ===== src/mrsa_csr.sv =====
// ---------------------------------------------------------------------------
// mrsa_csr - configuration registers
// Holds the allocation granule mask and the executable protection mask.
// ---------------------------------------------------------------------------
module mrsa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mrsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mrsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mrsa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [mrsa_pkg::MASK_W-1:0]        granule_mask,
   output logic [mrsa_pkg::MASK_W-1:0]        exec_mask
);

   logic [mrsa_pkg::MASK_W-1:0] granule_mask_ff, granule_mask_in;
   logic [mrsa_pkg::MASK_W-1:0] exec_mask_ff, exec_mask_in;
   logic                        wr_en;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      granule_mask_in = granule_mask_ff;
      exec_mask_in    = exec_mask_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            mrsa_pkg::CSR_GRANULE_MASK: granule_mask_in = csr_pwdata;
            mrsa_pkg::CSR_EXEC_MASK:    exec_mask_in    = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         granule_mask_ff <= 32'h0000_FFFF;
         exec_mask_ff    <= 32'h0000_00F0;
      end else begin
         granule_mask_ff <= granule_mask_in;
         exec_mask_ff    <= exec_mask_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mrsa_pkg::CSR_GRANULE_MASK: csr_prdata = granule_mask_ff;
         mrsa_pkg::CSR_EXEC_MASK:    csr_prdata = exec_mask_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready   = 1'b1;
   assign granule_mask = granule_mask_ff;
   assign exec_mask    = exec_mask_ff;

endmodule

// ===== src/mrsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// mrsa_ctrl - sequencing controller
// Walks each request through its steps and drives the datapath commands.
// ---------------------------------------------------------------------------
module mrsa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_type,
   output logic                      req_stall,
   input  mrsa_pkg::mrsa_status_type status,
   output mrsa_pkg::mrsa_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_GAP,
      ST_UPDATE,
      ST_BUBBLE,
      ST_READ
   } state_type;

   state_type                      state_ff, state_in;
   logic [mrsa_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                           accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               case (req_type)
                  mrsa_pkg::REQ_REGION: begin
                     cmd.load = 1'b1;
                     state_in = ST_UP;
                  end
                  mrsa_pkg::REQ_READ:  state_in = ST_READ;
                  mrsa_pkg::REQ_CLEAR: cmd.clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_UP: begin
            cmd.calc_up = 1'b1;
            state_in    = ST_GAP;
         end
         ST_GAP: begin
            cmd.calc_gap = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.free_hit ? ST_BUBBLE : ST_IDLE;
         end
         ST_BUBBLE: begin
            cmd.shift      = 1'b1;
            cmd.shift_last = (step_ff == mrsa_pkg::STEP_W'(mrsa_pkg::NUM_KEPT));
            if (cmd.shift_last) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_READ: begin
            if (status.out_room) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (step_ff == mrsa_pkg::STEP_W'(mrsa_pkg::NUM_STATS - 1));
               if (cmd.emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/mrsa_dpath.sv =====
// ---------------------------------------------------------------------------
// mrsa_dpath - statistics datapath
// Granule gap arithmetic, running totals, the largest-free shift line and
// the registered result stage.
// ---------------------------------------------------------------------------
module mrsa_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  mrsa_pkg::mrsa_cmd_type            cmd,
   output mrsa_pkg::mrsa_status_type         status,
   input  logic [mrsa_pkg::MASK_W-1:0]       granule_mask,
   input  logic [mrsa_pkg::MASK_W-1:0]       exec_mask,
   input  logic [mrsa_pkg::ADDR_W-1:0]       req_region_base,
   input  logic [mrsa_pkg::ADDR_W-1:0]       req_region_size,
   input  logic [1:0]                        req_region_state,
   input  logic [mrsa_pkg::MASK_W-1:0]       req_protect_flags,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mrsa_pkg::INDEX_W-1:0]      rsp_stat_index,
   output logic [mrsa_pkg::SUM_W-1:0]        rsp_stat_value,
   output logic                              rsp_last_of_run
);

   localparam int AW = mrsa_pkg::ADDR_W;
   localparam int MW = mrsa_pkg::MASK_W;
   localparam int SW = mrsa_pkg::SUM_W;
   localparam int CW = mrsa_pkg::COUNT_W;
   localparam int NT = mrsa_pkg::NUM_TOTALS;
   localparam int NK = mrsa_pkg::NUM_KEPT;
   localparam int KEPT_SEL_W = mrsa_pkg::KEPT_IDX_W;

   // captured descriptor
   logic [AW-1:0] base_ff, size_ff;
   logic [1:0]    region_ff;
   logic [MW-1:0] prot_ff;

   // gap pipeline
   logic [AW:0]   up_ff;
   logic          misaligned_ff;
   logic [MW-1:0] gap_ff;

   logic [SW-1:0] tot_ff [NT];
   logic [SW-1:0] tot_in [NT];
   logic [CW-1:0] cnt_ff [NT];
   logic [CW-1:0] cnt_in [NT];
   logic [AW-1:0] kept_ff [NK];
   logic [AW-1:0] kept_in [NK];
   logic [AW-1:0] carry_ff, carry_in;

   logic [AW-1:0] gap_wide, waste_amt, clamp_gap, bubble_out;
   logic [SW-1:0] size_sum;
   logic          exec_hit, carry_wins;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mrsa_pkg::INDEX_W-1:0]   index_ff;
   logic [SW-1:0]                  value_ff, value_sel;
   logic                           last_ff;
   logic [mrsa_pkg::STEP_W-1:0]    kept_off;
   logic [KEPT_SEL_W-1:0]          kept_sel;
   logic [mrsa_pkg::TOT_IDX_W-1:0] tot_sel;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff   <= req_region_base;
         size_ff   <= req_region_size;
         region_ff <= req_region_state;
         prot_ff   <= req_protect_flags;
      end
      if (cmd.calc_up) begin
         up_ff <= ({1'b0, base_ff} + {{(AW + 1 - MW){1'b0}}, granule_mask})
                  & ~{{(AW + 1 - MW){1'b0}}, granule_mask};
         misaligned_ff <= |(base_ff[MW-1:0] & granule_mask);
      end
      // gap never exceeds the mask, so it fits the mask width
      if (cmd.calc_gap) begin
         gap_ff <= MW'(up_ff - {1'b0, base_ff});
      end
   end

   assign gap_wide   = {{(AW - MW){1'b0}}, gap_ff};
   assign clamp_gap  = (gap_wide > size_ff) ? size_ff : gap_wide;
   assign waste_amt  = misaligned_ff ? gap_wide : '0;
   assign size_sum   = {{(SW - AW){1'b0}}, size_ff};
   assign exec_hit   = |(prot_ff & exec_mask);

   assign status.free_hit = (region_ff == mrsa_pkg::REGION_FREE) && (size_ff > waste_amt);
   assign status.out_room = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      for (int i = 0; i < NT; i++) begin
         tot_in[i] = tot_ff[i];
         cnt_in[i] = cnt_ff[i];
      end
      if (cmd.clear) begin
         for (int i = 0; i < NT; i++) begin
            tot_in[i] = '0;
            cnt_in[i] = '0;
         end
      end else if (cmd.update) begin
         if (exec_hit) begin
            tot_in[mrsa_pkg::TOT_EXEC] = tot_ff[mrsa_pkg::TOT_EXEC] + size_sum;
            cnt_in[mrsa_pkg::TOT_EXEC] = cnt_ff[mrsa_pkg::TOT_EXEC] + 1'b1;
         end
         case (region_ff)
            mrsa_pkg::REGION_RESERVED: begin
               tot_in[mrsa_pkg::TOT_RESV] = tot_ff[mrsa_pkg::TOT_RESV] + size_sum;
               cnt_in[mrsa_pkg::TOT_RESV] = cnt_ff[mrsa_pkg::TOT_RESV] + 1'b1;
            end
            mrsa_pkg::REGION_FREE: begin
               if (misaligned_ff) begin
                  tot_in[mrsa_pkg::TOT_WASTE] = tot_ff[mrsa_pkg::TOT_WASTE]
                                                + {{(SW - AW){1'b0}}, clamp_gap};
                  cnt_in[mrsa_pkg::TOT_WASTE] = cnt_ff[mrsa_pkg::TOT_WASTE] + 1'b1;
               end
               if (status.free_hit) begin
                  tot_in[mrsa_pkg::TOT_FREE] = tot_ff[mrsa_pkg::TOT_FREE] + size_sum;
                  cnt_in[mrsa_pkg::TOT_FREE] = cnt_ff[mrsa_pkg::TOT_FREE] + 1'b1;
               end
            end
            default: begin
               tot_in[mrsa_pkg::TOT_MAPPED] = tot_ff[mrsa_pkg::TOT_MAPPED] + size_sum;
               cnt_in[mrsa_pkg::TOT_MAPPED] = cnt_ff[mrsa_pkg::TOT_MAPPED] + 1'b1;
            end
         endcase
      end
   end

   // Bubble pass as a rotating shift line: the carried value meets the head
   // slot each cycle, the smaller one goes to the tail. The final step appends
   // the carry, leaving the kept slots in ascending order.
   assign carry_wins = carry_ff > kept_ff[0];
   assign bubble_out = cmd.shift_last ? carry_ff : (carry_wins ? kept_ff[0] : carry_ff);

   always_comb begin
      carry_in = carry_ff;
      for (int j = 0; j < NK; j++) begin
         kept_in[j] = kept_ff[j];
      end
      if (cmd.clear) begin
         for (int j = 0; j < NK; j++) begin
            kept_in[j] = '0;
         end
      end else if (cmd.update) begin
         carry_in = size_ff;
      end else if (cmd.shift) begin
         for (int j = 0; j < NK - 1; j++) begin
            kept_in[j] = kept_ff[j+1];
         end
         kept_in[NK-1] = bubble_out;
         if (!carry_wins) begin
            carry_in = kept_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            tot_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         for (int j = 0; j < NK; j++) begin
            kept_ff[j] <= '0;
         end
      end else begin
         for (int i = 0; i < NT; i++) begin
            tot_ff[i] <= tot_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
         for (int j = 0; j < NK; j++) begin
            kept_ff[j] <= kept_in[j];
         end
      end
   end

   // readout selection
   assign tot_sel  = cmd.step[mrsa_pkg::TOT_IDX_W:1];
   assign kept_off = cmd.step - mrsa_pkg::STEP_W'(2 * NT);
   assign kept_sel = kept_off[KEPT_SEL_W-1:0];

   always_comb begin
      value_sel = '0;
      if (cmd.step < mrsa_pkg::STEP_W'(2 * NT)) begin
         if (cmd.step[0]) begin
            value_sel = {{(SW - CW){1'b0}}, cnt_ff[tot_sel]};
         end else begin
            value_sel = tot_ff[tot_sel];
         end
      end else if (kept_off < mrsa_pkg::STEP_W'(NK)) begin
         value_sel = {{(SW - AW){1'b0}}, kept_ff[kept_sel]};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.out_room) begin
         rsp_valid_in = cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         index_ff <= mrsa_pkg::INDEX_W'(cmd.step);
         value_ff <= value_sel;
         last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stat_index  = index_ff;
   assign rsp_stat_value  = value_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== src/memory_region_stats_accumulator.sv =====
// ---------------------------------------------------------------------------
// memory_region_stats_accumulator - address-space region statistics
// Accumulates mapped, free, waste, executable and reserved totals and keeps
// the largest free region sizes; streams them out on request.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel takes one transaction at a time: a region descriptor, a
//   readout request or a clear. req_stall is high while a transaction is in
//   progress. rsp_* carries readout results through an output register; it
//   holds its payload while rsp_stall is high.
//   csr_* is an APB-style port: granule mask at 0x0, exec mask at 0x4.
// Sequencing:
//   descriptor   - load, up, gap and update steps; a free region larger than
//                  its alignment waste then runs the largest-free shift line.
//   clear/other  - done in the accepting cycle; req_stall stays low.
//   readout      - 17 results, one per cycle while the output register has
//                  room; the read state loads each into it. The next
//                  transaction is taken while the last result still waits.
// Reset clears all statistics, the kept free sizes and the output valid flag,
// and loads the masks with 0xFFFF and 0xF0.
// ---------------------------------------------------------------------------
module memory_region_stats_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [mrsa_pkg::ADDR_W-1:0]        req_region_base,
   input  logic [mrsa_pkg::ADDR_W-1:0]        req_region_size,
   input  logic [1:0]                         req_region_state,
   input  logic [mrsa_pkg::MASK_W-1:0]        req_protect_flags,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mrsa_pkg::INDEX_W-1:0]       rsp_stat_index,
   output logic [mrsa_pkg::SUM_W-1:0]         rsp_stat_value,
   output logic                               rsp_last_of_run,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mrsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mrsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mrsa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   mrsa_pkg::mrsa_cmd_type      cmd;
   mrsa_pkg::mrsa_status_type   status;
   logic [mrsa_pkg::MASK_W-1:0] granule_mask;
   logic [mrsa_pkg::MASK_W-1:0] exec_mask;

   mrsa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .granule_mask (granule_mask),
      .exec_mask    (exec_mask)
   );

   mrsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mrsa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .granule_mask      (granule_mask),
      .exec_mask         (exec_mask),
      .req_region_base   (req_region_base),
      .req_region_size   (req_region_size),
      .req_region_state  (req_region_state),
      .req_protect_flags (req_protect_flags),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stat_index    (rsp_stat_index),
      .rsp_stat_value    (rsp_stat_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
